// File: rtl/rtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_pkg - shared types and constants of the ringtone text note parser
// Field widths, result status codes, configuration register indexes, divider
// destinations and the command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
package rtp_pkg;

  // Field widths
  localparam int CHAR_W     = 8;
  localparam int NOTE_IDX_W = 6;
  localparam int BYTE_W     = 8;
  localparam int NOTE_NUM_W = 10;
  localparam int STATUS_W   = 2;
  localparam int FB_OCT_W   = 3;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] CFG_FB_DUR = 2'd0;
  localparam logic [1:0] CFG_FB_OCT = 2'd1;
  localparam logic [1:0] CFG_FB_MS  = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0]   RST_FB_DUR = 8'd16;
  localparam logic [FB_OCT_W-1:0] RST_FB_OCT = 3'd6;
  localparam logic [BYTE_W-1:0]   RST_FB_MS  = 8'd59;

  // Melody length limit
  localparam int RTP_MAX_NOTES = 1024;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_NOTE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_END   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABORT = 2'd2;

  // Divider
  localparam int DIV_NUM_W = 12;
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_NUM_W-1:0] NUM_WHOLE = 12'd64;
  localparam logic [DIV_NUM_W-1:0] NUM_TEMPO = 12'd3750;

  typedef enum logic [1:0] {
    DIV_DEF_DUR = 2'd0,
    DIV_TEMPO   = 2'd1,
    DIV_CUR_DUR = 2'd2
  } div_dest_t;

  // Pause note and octave base
  localparam logic [BYTE_W-1:0] NOTE_PAUSE = 8'd48;
  localparam logic [BYTE_W-1:0] OCT_BASE   = 8'd48;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LD    = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LO    = 8'h6F;

  // Commands from controller to datapath
  typedef struct packed {
    logic                char_load;
    logic                clear;
    logic                load_defaults;
    logic                set_hdr;
    logic                acc_clear;
    logic                acc_mac;
    logic                acc_digit;
    logic                set_def_oct;
    logic                note_start;
    logic                set_note;
    logic                note_inc;
    logic                note_dec;
    logic                grow;
    logic                set_cur_oct;
    logic                cnt_inc;
    logic                div_start;
    div_dest_t           div_dest;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic                emit_last;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic c_zero;
    logic c_colon;
    logic c_space;
    logic c_eq;
    logic c_comma;
    logic c_hash;
    logic c_flat;
    logic c_dot;
    logic c_digit;
    logic hdr_d;
    logic hdr_o;
    logic hdr_b;
    logic full;
    logic div_done;
  } stat_t;

endpackage

// File: rtl/rtp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_div - iterative restoring divider
// One quotient bit per cycle over the numerator width; a zero divisor gives 0.
// Quotient is truncated to eight bits.
// ----------------------------------------------------------------------------
module rtp_div import rtp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [BYTE_W-1:0]    den,
  output logic                 done,
  output logic [BYTE_W-1:0]    quot
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [BYTE_W-1:0]    rem_r, rem_nxt;
  logic [BYTE_W-1:0]    den_r, den_nxt;
  logic [BYTE_W:0]      rem_sh;
  logic [BYTE_W:0]      diff;
  logic                 ge;

  always_comb begin
    rem_sh   = {rem_r, num_r[DIV_NUM_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // shift one numerator bit in, subtract where it fits
      num_nxt = {num_r[DIV_NUM_W-2:0], ge};
      rem_nxt = ge ? diff[BYTE_W-1:0] : rem_sh[BYTE_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = (den_r == '0) ? '0 : num_r[BYTE_W-1:0];

endmodule

// File: rtl/rtp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_datapath - character register, header defaults and note arithmetic
// Executes controller commands, flags character classes and holds the
// result register.
// ----------------------------------------------------------------------------
module rtp_datapath import rtp_pkg::*; #(
  parameter int MAX_NOTES = RTP_MAX_NOTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 st,
  input  logic [CHAR_W-1:0]     in_character,
  input  logic [BYTE_W-1:0]     fb_dur,
  input  logic [FB_OCT_W-1:0]   fb_oct,
  input  logic [BYTE_W-1:0]     fb_ms,
  output logic [NOTE_IDX_W-1:0] out_note_index,
  output logic [BYTE_W-1:0]     out_duration_64ths,
  output logic [BYTE_W-1:0]     out_ms_per_64th,
  output logic [NOTE_NUM_W-1:0] out_note_number,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_last
);

  localparam logic [NOTE_NUM_W:0] MaxNotesW = (NOTE_NUM_W+1)'(MAX_NOTES);

  function automatic logic [BYTE_W-1:0] oct_offset(input logic [BYTE_W-1:0] o);
    // (o - 4) * 12, wrapped to eight bits
    oct_offset = {o[4:0], 3'b000} + {o[5:0], 2'b00} - OCT_BASE;
  endfunction

  function automatic logic [BYTE_W-1:0] letter_value(input logic [CHAR_W-1:0] c);
    case (c)
      8'h43, 8'h63:               letter_value = 8'd0;
      8'h44, 8'h64:               letter_value = 8'd2;
      8'h45, 8'h65:               letter_value = 8'd4;
      8'h46, 8'h66:               letter_value = 8'd5;
      8'h47, 8'h67:               letter_value = 8'd7;
      8'h41, 8'h61:               letter_value = 8'd9;
      8'h48, 8'h68, 8'h42, 8'h62: letter_value = 8'd11;
      default:                    letter_value = NOTE_PAUSE;
    endcase
  endfunction

  logic [CHAR_W-1:0]     char_r, char_nxt;
  logic [CHAR_W-1:0]     hdr_r, hdr_nxt;
  logic [BYTE_W-1:0]     acc_r, acc_nxt;
  logic [BYTE_W-1:0]     def_dur_r, def_dur_nxt;
  logic [BYTE_W-1:0]     def_oct_r, def_oct_nxt;
  logic [BYTE_W-1:0]     tempo_r, tempo_nxt;
  logic [BYTE_W-1:0]     cur_dur_r, cur_dur_nxt;
  logic [BYTE_W-1:0]     cur_note_r, cur_note_nxt;
  logic [BYTE_W-1:0]     cur_oct_r, cur_oct_nxt;
  logic [NOTE_NUM_W-1:0] cnt_r, cnt_nxt;
  div_dest_t             dest_r, dest_nxt;

  logic [NOTE_IDX_W-1:0] o_idx_r, o_idx_nxt;
  logic [BYTE_W-1:0]     o_dur_r, o_dur_nxt;
  logic [BYTE_W-1:0]     o_ms_r, o_ms_nxt;
  logic [NOTE_NUM_W-1:0] o_num_r, o_num_nxt;
  logic [STATUS_W-1:0]   o_st_r, o_st_nxt;
  logic                  o_last_r, o_last_nxt;

  logic [BYTE_W-1:0]     digit;
  logic [BYTE_W-1:0]     note_sum;
  logic [BYTE_W-1:0]     note_idx;
  logic [DIV_NUM_W-1:0]  div_num;
  logic                  div_done;
  logic [BYTE_W-1:0]     div_quot;

  assign digit    = char_r - CH_ZERO;
  assign note_sum = cur_note_r + cur_oct_r;
  assign note_idx = (note_sum > NOTE_PAUSE) ? NOTE_PAUSE : note_sum;
  assign div_num  = (cmd.div_dest == DIV_TEMPO) ? NUM_TEMPO : NUM_WHOLE;

  rtp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (acc_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    st.c_zero   = (char_r == CH_NUL);
    st.c_colon  = (char_r == CH_COLON);
    st.c_space  = (char_r == CH_SPACE);
    st.c_eq     = (char_r == CH_EQ);
    st.c_comma  = (char_r == CH_COMMA);
    st.c_hash   = (char_r == CH_HASH);
    st.c_flat   = (char_r == CH_LB);
    st.c_dot    = (char_r == CH_DOT);
    st.c_digit  = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
    st.hdr_d    = (hdr_r == CH_LD);
    st.hdr_o    = (hdr_r == CH_LO);
    st.hdr_b    = (hdr_r == CH_LB);
    st.full     = (({1'b0, cnt_r} + 1'b1) >= MaxNotesW);
    st.div_done = div_done;
  end

  always_comb begin
    char_nxt     = cmd.char_load ? in_character : char_r;
    hdr_nxt      = hdr_r;
    acc_nxt      = acc_r;
    def_dur_nxt  = def_dur_r;
    def_oct_nxt  = def_oct_r;
    tempo_nxt    = tempo_r;
    cur_dur_nxt  = cur_dur_r;
    cur_note_nxt = cur_note_r;
    cur_oct_nxt  = cur_oct_r;
    cnt_nxt      = cnt_r;
    dest_nxt     = cmd.div_start ? cmd.div_dest : dest_r;

    if (cmd.load_defaults) begin
      def_dur_nxt = fb_dur;
      def_oct_nxt = oct_offset({{(BYTE_W-FB_OCT_W){1'b0}}, fb_oct});
      tempo_nxt   = fb_ms;
    end
    if (cmd.set_hdr)     hdr_nxt = char_r;
    if (cmd.acc_clear)   acc_nxt = '0;
    if (cmd.acc_mac)     acc_nxt = {acc_r[4:0], 3'b000} + {acc_r[6:0], 1'b0} + digit;
    if (cmd.acc_digit)   acc_nxt = digit;
    if (cmd.set_def_oct) def_oct_nxt = oct_offset(acc_r);
    if (cmd.note_start) begin
      cur_dur_nxt = def_dur_r;
      cur_oct_nxt = def_oct_r;
    end
    if (cmd.set_note)    cur_note_nxt = letter_value(char_r);
    if (cmd.note_inc)    cur_note_nxt = cur_note_r + 1'b1;
    if (cmd.note_dec)    cur_note_nxt = cur_note_r - 1'b1;
    if (cmd.grow)        cur_dur_nxt = cur_dur_r + {1'b0, cur_dur_r[BYTE_W-1:1]};
    if (cmd.set_cur_oct) cur_oct_nxt = oct_offset(digit);
    if (cmd.cnt_inc)     cnt_nxt = cnt_r + 1'b1;

    // write the quotient where the division was aimed
    if (div_done) begin
      case (dest_r)
        DIV_DEF_DUR: def_dur_nxt = div_quot;
        DIV_TEMPO:   tempo_nxt   = div_quot;
        DIV_CUR_DUR: cur_dur_nxt = div_quot;
        default:     cur_dur_nxt = cur_dur_r;
      endcase
    end

    if (cmd.clear) begin
      hdr_nxt      = '0;
      acc_nxt      = '0;
      cur_dur_nxt  = '0;
      cur_note_nxt = '0;
      cur_oct_nxt  = '0;
      cnt_nxt      = '0;
    end
  end

  always_comb begin
    o_idx_nxt  = o_idx_r;
    o_dur_nxt  = o_dur_r;
    o_ms_nxt   = o_ms_r;
    o_num_nxt  = o_num_r;
    o_st_nxt   = o_st_r;
    o_last_nxt = o_last_r;
    if (cmd.emit) begin
      o_st_nxt   = cmd.emit_status;
      o_last_nxt = cmd.emit_last;
      o_idx_nxt  = '0;
      o_dur_nxt  = '0;
      o_ms_nxt   = '0;
      o_num_nxt  = '0;
      case (cmd.emit_status)
        ST_NOTE: begin
          o_idx_nxt = note_idx[NOTE_IDX_W-1:0];
          o_dur_nxt = cur_dur_r;
          o_ms_nxt  = tempo_r;
          o_num_nxt = cnt_r;
        end
        ST_END: begin
          o_num_nxt = cnt_r;
        end
        default: begin
          o_num_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= '0;
      acc_r      <= '0;
      def_dur_r  <= RST_FB_DUR;
      def_oct_r  <= oct_offset({{(BYTE_W-FB_OCT_W){1'b0}}, RST_FB_OCT});
      tempo_r    <= RST_FB_MS;
      cur_dur_r  <= '0;
      cur_note_r <= '0;
      cur_oct_r  <= '0;
      cnt_r      <= '0;
      dest_r     <= DIV_DEF_DUR;
    end else begin
      hdr_r      <= hdr_nxt;
      acc_r      <= acc_nxt;
      def_dur_r  <= def_dur_nxt;
      def_oct_r  <= def_oct_nxt;
      tempo_r    <= tempo_nxt;
      cur_dur_r  <= cur_dur_nxt;
      cur_note_r <= cur_note_nxt;
      cur_oct_r  <= cur_oct_nxt;
      cnt_r      <= cnt_nxt;
      dest_r     <= dest_nxt;
    end
    char_r   <= char_nxt;
    o_idx_r  <= o_idx_nxt;
    o_dur_r  <= o_dur_nxt;
    o_ms_r   <= o_ms_nxt;
    o_num_r  <= o_num_nxt;
    o_st_r   <= o_st_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_note_index     = o_idx_r;
  assign out_duration_64ths = o_dur_r;
  assign out_ms_per_64th    = o_ms_r;
  assign out_note_number    = o_num_r;
  assign out_status         = o_st_r;
  assign out_last           = o_last_r;

endmodule

// File: rtl/rtp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_ctrl - parse state machine and item sequencer
// Tracks title, header and note phases, steps one parse decision per cycle
// unless divider or output holds it; issues datapath commands, owns out_valid.
// ----------------------------------------------------------------------------
module rtp_ctrl import rtp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    SEQ_IDLE = 3'b001,
    SEQ_EVAL = 3'b010,
    SEQ_DIV  = 3'b100
  } seq_t;

  typedef enum logic [14:0] {
    PS_TITLE    = 15'h0001,
    PS_DONE     = 15'h0002,
    PS_H_KEY    = 15'h0004,
    PS_H_EQ     = 15'h0008,
    PS_H_VAL    = 15'h0010,
    PS_H_AFTER  = 15'h0020,
    PS_N_START  = 15'h0040,
    PS_N_DUR    = 15'h0080,
    PS_N_LETTER = 15'h0100,
    PS_N_SHARP  = 15'h0200,
    PS_N_FLAT   = 15'h0400,
    PS_N_DOT1   = 15'h0800,
    PS_N_OCT    = 15'h1000,
    PS_N_DOT2   = 15'h2000,
    PS_N_DELIM  = 15'h4000
  } pst_t;

  seq_t seq_r, seq_nxt, seq_c;
  pst_t pst_r, pst_nxt, pst_c;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  cmd_t cmd_c;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd_c = '0;
    pst_c = pst_r;
    seq_c = seq_r;
    case (seq_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          cmd_c.char_load = 1'b1;
          seq_c = SEQ_EVAL;
        end
      end
      SEQ_DIV: begin
        if (st.div_done) seq_c = SEQ_EVAL;
      end
      SEQ_EVAL: begin
        // finish with this character unless a branch carries it on
        seq_c = SEQ_IDLE;
        case (pst_r)
          PS_TITLE: begin
            if (st.c_colon) begin
              cmd_c.load_defaults = 1'b1;
              pst_c = PS_H_KEY;
            end else if (st.c_zero) begin
              cmd_c.emit = 1'b1;
              cmd_c.emit_status = ST_ABORT;
              cmd_c.emit_last = 1'b1;
              cmd_c.clear = 1'b1;
              pst_c = PS_TITLE;
            end
          end
          PS_DONE: begin
            if (st.c_zero) begin
              cmd_c.clear = 1'b1;
              pst_c = PS_TITLE;
            end
          end
          PS_H_KEY: begin
            if (st.c_space) begin
              pst_c = PS_H_KEY;
            end else if (st.c_zero) begin
              cmd_c.emit = 1'b1;
              cmd_c.emit_status = ST_ABORT;
              cmd_c.emit_last = 1'b1;
              cmd_c.clear = 1'b1;
              pst_c = PS_TITLE;
            end else if (st.c_colon) begin
              pst_c = PS_N_START;
            end else begin
              cmd_c.set_hdr = 1'b1;
              pst_c = PS_H_EQ;
            end
          end
          PS_H_EQ: begin
            if (st.c_eq) begin
              cmd_c.acc_clear = 1'b1;
              pst_c = PS_H_VAL;
            end else begin
              cmd_c.emit = 1'b1;
              cmd_c.emit_status = ST_ABORT;
              cmd_c.emit_last = 1'b1;
              if (st.c_zero) begin
                cmd_c.clear = 1'b1;
                pst_c = PS_TITLE;
              end else begin
                pst_c = PS_DONE;
              end
            end
          end
          PS_H_VAL: begin
            if (st.c_digit) begin
              cmd_c.acc_mac = 1'b1;
            end else begin
              pst_c = PS_H_AFTER;
              if (st.hdr_d) begin
                cmd_c.div_start = 1'b1;
                cmd_c.div_dest = DIV_DEF_DUR;
                seq_c = SEQ_DIV;
              end else if (st.hdr_b) begin
                cmd_c.div_start = 1'b1;
                cmd_c.div_dest = DIV_TEMPO;
                seq_c = SEQ_DIV;
              end else begin
                cmd_c.set_def_oct = st.hdr_o;
                seq_c = SEQ_EVAL;
              end
            end
          end
          PS_H_AFTER: begin
            if (!st.c_space) begin
              pst_c = PS_H_KEY;
              if (!st.c_comma) seq_c = SEQ_EVAL;
            end
          end
          PS_N_START: begin
            if (st.c_zero) begin
              cmd_c.emit = 1'b1;
              cmd_c.emit_status = ST_END;
              cmd_c.emit_last = 1'b1;
              cmd_c.clear = 1'b1;
              pst_c = PS_TITLE;
            end else if (!st.c_space) begin
              cmd_c.note_start = 1'b1;
              if (st.c_digit) begin
                cmd_c.acc_digit = 1'b1;
                pst_c = PS_N_DUR;
              end else begin
                cmd_c.set_note = 1'b1;
                pst_c = PS_N_SHARP;
              end
            end
          end
          PS_N_DUR: begin
            if (st.c_digit) begin
              cmd_c.acc_mac = 1'b1;
            end else begin
              cmd_c.div_start = 1'b1;
              cmd_c.div_dest = DIV_CUR_DUR;
              pst_c = PS_N_LETTER;
              seq_c = SEQ_DIV;
            end
          end
          PS_N_LETTER: begin
            if (st.c_zero) begin
              cmd_c.emit = 1'b1;
              cmd_c.emit_status = ST_END;
              cmd_c.emit_last = 1'b1;
              cmd_c.clear = 1'b1;
              pst_c = PS_TITLE;
            end else begin
              cmd_c.set_note = 1'b1;
              pst_c = PS_N_SHARP;
            end
          end
          PS_N_SHARP: begin
            pst_c = PS_N_FLAT;
            if (st.c_hash) cmd_c.note_inc = 1'b1;
            else seq_c = SEQ_EVAL;
          end
          PS_N_FLAT: begin
            pst_c = PS_N_DOT1;
            if (st.c_flat) cmd_c.note_dec = 1'b1;
            else seq_c = SEQ_EVAL;
          end
          PS_N_DOT1: begin
            pst_c = PS_N_OCT;
            if (st.c_dot) cmd_c.grow = 1'b1;
            else seq_c = SEQ_EVAL;
          end
          PS_N_OCT: begin
            pst_c = PS_N_DOT2;
            if (st.c_digit) cmd_c.set_cur_oct = 1'b1;
            else seq_c = SEQ_EVAL;
          end
          PS_N_DOT2: begin
            pst_c = PS_N_DELIM;
            if (st.c_dot) cmd_c.grow = 1'b1;
            else seq_c = SEQ_EVAL;
          end
          PS_N_DELIM: begin
            if (!st.c_space) begin
              cmd_c.emit = 1'b1;
              cmd_c.emit_status = ST_NOTE;
              cmd_c.emit_last = st.c_zero || st.full;
              cmd_c.cnt_inc = 1'b1;
              if (st.c_zero) begin
                cmd_c.clear = 1'b1;
                pst_c = PS_TITLE;
              end else if (st.full) begin
                pst_c = PS_DONE;
              end else begin
                pst_c = PS_N_START;
                if (!st.c_comma) seq_c = SEQ_EVAL;
              end
            end
          end
          default: begin
            cmd_c.clear = 1'b1;
            pst_c = PS_TITLE;
          end
        endcase
      end
      default: seq_c = SEQ_IDLE;
    endcase
  end

  // hold everything while a result must go out and the output is still full
  always_comb begin
    if (cmd_c.emit && !slot_free) begin
      cmd     = '0;
      pst_nxt = pst_r;
      seq_nxt = seq_r;
    end else begin
      cmd     = cmd_c;
      pst_nxt = pst_c;
      seq_nxt = seq_c;
    end
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SEQ_IDLE;
      pst_r       <= PS_TITLE;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      pst_r       <= pst_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (seq_r != SEQ_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_evaluates: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (seq_r == SEQ_EVAL))
    else $error("accepted character not taken into evaluation");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result written over a waiting result");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (seq_r == SEQ_DIV))
    else $error("division finished while not waiting for it");

  a_div_start_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (seq_r == SEQ_DIV))
    else $error("division started without waiting for it");
`endif

endmodule

// File: rtl/ringtone_text_note_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ringtone_text_note_parser_top - ringtone text to note stream
// Parses a ringtone text one character at a time and emits one note per
// delimiter, with end-of-melody and malformed-header results.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel: one character per transfer on in_character (in_valid,
//  in_stall); a zero character ends the string. Title characters up to the
//  first colon are skipped, the d=, o= and b= header follows, then notes.
//  Result channel: at most one result per character (out_valid, out_stall),
//  status 0 note, 1 end of melody, 2 malformed header; out_last marks the
//  final result of a string.
//  Timing: a character is taken in the idle step and then evaluated one parse
//  step per cycle unless the divider or a waiting result holds it; a delimiter
//  can run through the optional note suffixes. A character that closes a d or b
//  header value or a duration number also runs the shift-subtract divider, and
//  then resumes evaluation, going on to the next header key where it opens one.
//  The result appears the cycle after its evaluation.
//  Stall: a finished result waits in the output register while the next
//  character is taken; evaluation holds only when a new result is due and
//  the old one is still waiting.
//  Reset: back to the title phase with the fallback register defaults.
// ----------------------------------------------------------------------------
module ringtone_text_note_parser_top import rtp_pkg::*; #(
  parameter int MAX_NOTES = RTP_MAX_NOTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     in_character,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [NOTE_IDX_W-1:0] out_note_index,
  output logic [BYTE_W-1:0]     out_duration_64ths,
  output logic [BYTE_W-1:0]     out_ms_per_64th,
  output logic [NOTE_NUM_W-1:0] out_note_number,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  logic [BYTE_W-1:0]   fb_dur_r, fb_dur_nxt;
  logic [FB_OCT_W-1:0] fb_oct_r, fb_oct_nxt;
  logic [BYTE_W-1:0]   fb_ms_r, fb_ms_nxt;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;
  cmd_t                cmd;
  stat_t               st;

  // Configuration registers: written in the access phase, read back as is
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    fb_dur_nxt = fb_dur_r;
    fb_oct_nxt = fb_oct_r;
    fb_ms_nxt  = fb_ms_r;
    if (cfg_wr) begin
      case (cfg_idx)
        CFG_FB_DUR: fb_dur_nxt = pwdata[BYTE_W-1:0];
        CFG_FB_OCT: fb_oct_nxt = pwdata[FB_OCT_W-1:0];
        CFG_FB_MS:  fb_ms_nxt  = pwdata[BYTE_W-1:0];
        default:    fb_dur_nxt = fb_dur_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_FB_DUR: prdata = {{(PDATA_W-BYTE_W){1'b0}}, fb_dur_r};
      CFG_FB_OCT: prdata = {{(PDATA_W-FB_OCT_W){1'b0}}, fb_oct_r};
      CFG_FB_MS:  prdata = {{(PDATA_W-BYTE_W){1'b0}}, fb_ms_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_dur_r <= RST_FB_DUR;
      fb_oct_r <= RST_FB_OCT;
      fb_ms_r  <= RST_FB_MS;
    end else begin
      fb_dur_r <= fb_dur_nxt;
      fb_oct_r <= fb_oct_nxt;
      fb_ms_r  <= fb_ms_nxt;
    end
  end

  // Parse control: sequences each transfer and owns the result valid flag
  rtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: character, header defaults, note arithmetic, result register
  rtp_datapath #(
    .MAX_NOTES (MAX_NOTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_character       (in_character),
    .fb_dur             (fb_dur_r),
    .fb_oct             (fb_oct_r),
    .fb_ms              (fb_ms_r),
    .out_note_index     (out_note_index),
    .out_duration_64ths (out_duration_64ths),
    .out_ms_per_64th    (out_ms_per_64th),
    .out_note_number    (out_note_number),
    .out_status         (out_status),
    .out_last           (out_last)
  );

endmodule
